// File: rtl/min_line_envelope_tree_unit_assert.svh
// ----------------------------------------------------------------------------
// min_line_envelope_tree_unit_assert.svh
// Assertion macros for the line envelope tree RTL.
// ----------------------------------------------------------------------------
`ifndef MIN_LINE_ENVELOPE_TREE_UNIT_ASSERT_SVH
`define MIN_LINE_ENVELOPE_TREE_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define MLET_CHECK(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define MLET_CHECK_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mlet_pkg.sv
// ----------------------------------------------------------------------------
// mlet_pkg
// Types and constants for the minimum line envelope tree.
// ----------------------------------------------------------------------------
package mlet_pkg;

   localparam int DomainSizeDefault = 1024;

   localparam int SlopeW = 32;
   localparam int IcptW  = 63;
   localparam int CoordW = 11;
   localparam int PointW = 10;
   localparam int ProdW  = SlopeW + CoordW + 1;
   localparam int SumW   = 64;

   localparam logic signed [IcptW-1:0] EmptyValue = 63'sd4000000000000000000;

   typedef struct packed {
      logic signed [SlopeW-1:0] slope;
      logic signed [IcptW-1:0]  icpt;
   } line_type;

   localparam line_type EmptyLine = '{slope: '0, icpt: EmptyValue};

   typedef struct packed {
      logic signed [SumW-1:0] sum_a;
      logic signed [SumW-1:0] sum_b;
      logic                   a_lt_b;
      logic                   b_lt_a;
   } eval_type;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_QUERY  = 1'b1
   } req_kind_type;

   // register index (byte address bit 2)
   localparam logic RegDomainSize = 1'b0;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RANGE,
      S_PL_RD,
      S_PL_MID,
      S_PL_CMID,
      S_PL_CLO,
      S_PL_CHI,
      S_Q_RD,
      S_Q_MUL,
      S_Q_ACC,
      S_Q_DONE
   } mlet_state_type;

endpackage

// File: rtl/mlet_line_eval.sv
// ----------------------------------------------------------------------------
// mlet_line_eval
// Evaluates two lines at one point: registered products, then add/compare.
// ----------------------------------------------------------------------------
module mlet_line_eval (
   input  logic                        clock,
   input  mlet_pkg::line_type          line_a,
   input  mlet_pkg::line_type          line_b,
   input  logic [mlet_pkg::CoordW-1:0] x,
   output mlet_pkg::eval_type          res
);
   import mlet_pkg::*;

   logic signed [ProdW-1:0] prod_a_ff, prod_a_in;
   logic signed [ProdW-1:0] prod_b_ff, prod_b_in;
   logic signed [CoordW:0]  x_s;

   assign x_s       = $signed({1'b0, x});
   assign prod_a_in = line_a.slope * x_s;
   assign prod_b_in = line_b.slope * x_s;

   always_ff @(posedge clock) begin
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
   end

   // intercepts are held steady by the caller across the product cycle
   always_comb begin
      res.sum_a  = SumW'(prod_a_ff) + SumW'(line_a.icpt);
      res.sum_b  = SumW'(prod_b_ff) + SumW'(line_b.icpt);
      res.a_lt_b = res.sum_a < res.sum_b;
      res.b_lt_a = res.sum_b < res.sum_a;
   end

endmodule

// File: rtl/min_line_envelope_tree_unit.sv
// ----------------------------------------------------------------------------
// min_line_envelope_tree_unit
// Li Chao tree (minimum) over points 0..n-1 with a heap-indexed node memory.
// ----------------------------------------------------------------------------
//  channel | ports                                   | moves
//  --------+-----------------------------------------+-------------------------
//  req     | req_valid/req_ready, req_type..req_point | insert or query item
//  rsp     | rsp_valid/rsp_ready, rsp_min_value       | one item per query
//  csr     | psel/penable/pwrite/paddr/pwdata/prdata  | domain_size register
//
//  After reset a clearing pass writes the empty line into all 4*DOMAIN_SIZE
//  nodes, one per cycle; req_ready stays low until it ends.
//  Query: per tree level a read, a multiply and an add/compare, then a
//  done step that waits for the output register to free.
//  Insert: a walk over the range nodes, then for each node that a line is
//  placed or pushed through, a read and compares at mid, low and high end.
//  A finished query result waits in the output register; inserts go on
//  meanwhile, and a second query holds at its end until the register frees.
module min_line_envelope_tree_unit #(
   parameter int DOMAIN_SIZE = mlet_pkg::DomainSizeDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_type,
   input  logic signed [mlet_pkg::SlopeW-1:0] req_slope,
   input  logic signed [mlet_pkg::IcptW-1:0]  req_intercept,
   input  logic [mlet_pkg::CoordW-1:0]        req_range_low,
   input  logic [mlet_pkg::CoordW-1:0]        req_range_high,
   input  logic [mlet_pkg::PointW-1:0]        req_point,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [mlet_pkg::IcptW-1:0]  rsp_min_value,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [2:0]                         paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import mlet_pkg::*;
   `include "min_line_envelope_tree_unit_assert.svh"

   localparam int NodeCount  = 4 * DOMAIN_SIZE;
   localparam int AW         = $clog2(NodeCount);
   localparam int StackDepth = AW;
   localparam int SpW        = $clog2(StackDepth + 1);
   localparam int SpIdxW     = $clog2(StackDepth);
   localparam int NCap       = (DOMAIN_SIZE > 2047) ? 2047 : DOMAIN_SIZE;

   mlet_state_type state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [CoordW-1:0] domain_ff;
   logic [CoordW-1:0] ql_ff, ql_in, qr_ff, qr_in;
   logic [AW-1:0]     cur_idx_ff, cur_idx_in;
   logic [CoordW-1:0] cur_lo_ff, cur_lo_in, cur_hi_ff, cur_hi_in;
   line_type          ins_line_ff, ins_line_in;
   line_type          car_ff, car_in;
   logic              swap_ff, swap_in;
   logic [PointW-1:0] pt_ff, pt_in;
   logic signed [IcptW-1:0] best_ff, best_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [IcptW-1:0] rsp_min_ff, rsp_min_in;
   logic [SpW-1:0]    sp_ff, sp_in;

   logic [AW-1:0]     stk_idx_ff [StackDepth];
   logic [CoordW-1:0] stk_lo_ff  [StackDepth];
   logic [CoordW-1:0] stk_hi_ff  [StackDepth];

   line_type          mem [NodeCount];
   line_type          rdata_ff;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr;
   line_type          mem_wdata;

   logic              push_en, pop_req, rsp_load;
   logic [CoordW-1:0] n_eff, mid, eval_x, rh_clip;
   logic [AW-1:0]     left_idx, right_idx;
   logic              leaf, covered;
   logic [SpIdxW-1:0] top_pos;
   logic signed [IcptW-1:0] v_clamp;
   eval_type          ev;

   // ---------------------------------------------------------------- config
   always_comb begin
      if (domain_ff == '0) begin
         n_eff = CoordW'(1);
      end else if (domain_ff > CoordW'(NCap)) begin
         n_eff = CoordW'(NCap);
      end else begin
         n_eff = domain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         domain_ff <= CoordW'(1024);
      end else if (psel && penable && pwrite && paddr[2] == RegDomainSize) begin
         domain_ff <= pwdata[CoordW-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == RegDomainSize) ? 32'(domain_ff) : '0;

   // ---------------------------------------------------------------- helpers
   assign mid       = CoordW'(({1'b0, cur_lo_ff} + {1'b0, cur_hi_ff}) >> 1);
   assign left_idx  = {cur_idx_ff[AW-2:0], 1'b0};
   assign right_idx = {cur_idx_ff[AW-2:0], 1'b1};
   assign leaf      = (cur_hi_ff - cur_lo_ff) <= CoordW'(1);
   assign covered   = (ql_ff <= cur_lo_ff) && (cur_hi_ff <= qr_ff);
   assign top_pos   = SpIdxW'(sp_ff - SpW'(1));
   assign rh_clip   = (req_range_high > n_eff) ? n_eff : req_range_high;

   always_comb begin
      if (ev.sum_b > SumW'(EmptyValue)) begin
         v_clamp = EmptyValue;
      end else if (ev.sum_b < -SumW'(EmptyValue)) begin
         v_clamp = -EmptyValue;
      end else begin
         v_clamp = IcptW'(ev.sum_b);
      end
   end

   mlet_line_eval u_eval (
      .clock  (clock),
      .line_a (car_ff),
      .line_b (rdata_ff),
      .x      (eval_x),
      .res    (ev)
   );

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ql_in        = ql_ff;
      qr_in        = qr_ff;
      cur_idx_in   = cur_idx_ff;
      cur_lo_in    = cur_lo_ff;
      cur_hi_in    = cur_hi_ff;
      ins_line_in  = ins_line_ff;
      car_in       = car_ff;
      swap_in      = swap_ff;
      pt_in        = pt_ff;
      best_in      = best_ff;
      sp_in        = sp_ff;
      push_en      = 1'b0;
      pop_req      = 1'b0;
      rsp_load     = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = cur_idx_ff;
      mem_wdata    = car_ff;
      eval_x       = mid;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = EmptyLine;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(NodeCount - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cur_idx_in = AW'(1);
               cur_lo_in  = '0;
               cur_hi_in  = n_eff;
               sp_in      = '0;
               if (req_kind_type'(req_type) == REQ_QUERY) begin
                  pt_in    = req_point;
                  best_in  = EmptyValue;
                  state_in = S_Q_RD;
               end else begin
                  ins_line_in = '{slope: req_slope, icpt: req_intercept};
                  ql_in       = req_range_low;
                  qr_in       = rh_clip;
                  if (req_range_low < rh_clip) begin
                     state_in = S_RANGE;
                  end
               end
            end
         end
         S_RANGE: begin
            if (covered) begin
               car_in   = ins_line_ff;
               state_in = S_PL_RD;
            end else if (leaf) begin
               pop_req = 1'b1;
            end else if (ql_ff < mid && mid < qr_ff) begin
               push_en    = 1'b1;
               sp_in      = sp_ff + 1'b1;
               cur_idx_in = left_idx;
               cur_hi_in  = mid;
            end else if (ql_ff < mid) begin
               cur_idx_in = left_idx;
               cur_hi_in  = mid;
            end else if (mid < qr_ff) begin
               cur_idx_in = right_idx;
               cur_lo_in  = mid;
            end else begin
               pop_req = 1'b1;
            end
         end
         S_PL_RD: begin
            mem_re   = 1'b1;
            state_in = S_PL_MID;
         end
         S_PL_MID: begin
            state_in = S_PL_CMID;
         end
         S_PL_CMID: begin
            // carried line lower at mid: it takes the node
            eval_x  = cur_lo_ff;
            swap_in = ev.a_lt_b;
            mem_we  = ev.a_lt_b;
            if (leaf) begin
               pop_req = 1'b1;
            end else begin
               state_in = S_PL_CLO;
            end
         end
         S_PL_CLO: begin
            eval_x = cur_hi_ff - CoordW'(1);
            if (swap_ff ? ev.b_lt_a : ev.a_lt_b) begin
               car_in     = swap_ff ? rdata_ff : car_ff;
               cur_idx_in = left_idx;
               cur_hi_in  = mid;
               state_in   = S_PL_RD;
            end else begin
               state_in = S_PL_CHI;
            end
         end
         S_PL_CHI: begin
            if (swap_ff ? ev.b_lt_a : ev.a_lt_b) begin
               car_in     = swap_ff ? rdata_ff : car_ff;
               cur_idx_in = right_idx;
               cur_lo_in  = mid;
               state_in   = S_PL_RD;
            end else begin
               pop_req = 1'b1;
            end
         end
         S_Q_RD: begin
            mem_re   = 1'b1;
            state_in = S_Q_MUL;
         end
         S_Q_MUL: begin
            eval_x   = {1'b0, pt_ff};
            state_in = S_Q_ACC;
         end
         S_Q_ACC: begin
            if (v_clamp < best_ff) begin
               best_in = v_clamp;
            end
            if (leaf) begin
               state_in = S_Q_DONE;
            end else if ({1'b0, pt_ff} < mid) begin
               cur_idx_in = left_idx;
               cur_hi_in  = mid;
               state_in   = S_Q_RD;
            end else begin
               cur_idx_in = right_idx;
               cur_lo_in  = mid;
               state_in   = S_Q_RD;
            end
         end
         S_Q_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // resume the next pending right subtree of the range split, or go idle if none is pending
      if (pop_req) begin
         if (sp_ff == '0) begin
            state_in = S_IDLE;
         end else begin
            cur_idx_in = stk_idx_ff[top_pos];
            cur_lo_in  = stk_lo_ff[top_pos];
            cur_hi_in  = stk_hi_ff[top_pos];
            sp_in      = sp_ff - 1'b1;
            state_in   = S_RANGE;
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_min_in   = rsp_min_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_min_in   = best_ff;
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_min_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ql_ff       <= ql_in;
      qr_ff       <= qr_in;
      cur_idx_ff  <= cur_idx_in;
      cur_lo_ff   <= cur_lo_in;
      cur_hi_ff   <= cur_hi_in;
      ins_line_ff <= ins_line_in;
      car_ff      <= car_in;
      swap_ff     <= swap_in;
      pt_ff       <= pt_in;
      best_ff     <= best_in;
      rsp_min_ff  <= rsp_min_in;
      if (push_en) begin
         stk_idx_ff[SpIdxW'(sp_ff)] <= right_idx;
         stk_lo_ff[SpIdxW'(sp_ff)]  <= mid;
         stk_hi_ff[SpIdxW'(sp_ff)]  <= cur_hi_ff;
      end
   end

   // node memory, one write and one read port, registered read data
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[cur_idx_ff];
      end
   end

   // ---------------------------------------------------------------- checks
   `MLET_CHECK(a_stack_bound, clock, reset, 1'b1, sp_ff <= SpW'(StackDepth), "stack overflow")
   `MLET_CHECK(a_write_src, clock, reset, mem_we, (state_ff == S_CLEAR || state_ff == S_PL_CMID), "stray node write")
   `MLET_CHECK(a_span_order, clock, reset, (state_ff != S_IDLE && state_ff != S_CLEAR), cur_lo_ff < cur_hi_ff, "empty node span")
   `MLET_CHECK_NEXT(a_rsp_source, clock, reset, (!rsp_valid_ff && state_ff != S_Q_DONE), !rsp_valid_ff, "result without query")

endmodule
